// ===== rtl/core/slid_pkg.sv =====
// Shared types and constants for the sorted list insert/delete block.
// No dependencies; imported by slid_ctrl, slid_datapath and the top level.
`default_nettype none

package slid_pkg;

   localparam int DEF_CAPACITY = 16;
   localparam int VALUE_W      = 32;
   localparam int ENTRY_W      = 5;
   localparam int STATUS_W     = 2;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE   = 1'b0,
      S_UPDATE = 1'b1
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch transaction and compare against all cells
      logic update;    // apply shift, count change and load response
   } cmd_type;

endpackage : slid_pkg

`default_nettype wire

// ===== rtl/core/slid_datapath.sv =====
// Datapath: row of sorted value cells with per-cell comparators, count and
// response payload registers. Depends on slid_pkg; driven by slid_ctrl commands.
`default_nettype none

module slid_datapath
   import slid_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   input  logic                       req_opcode,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [ENTRY_W-1:0]         rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic signed [VALUE_W-1:0] entries_ff [CAPACITY];
   logic signed [VALUE_W-1:0] entries_in [CAPACITY];
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CAPACITY-1:0]       lt_ff, lt_in;
   logic [CAPACITY-1:0]       eq_ff, eq_in;
   op_type                    op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   status_type                status_ff, status_in;
   logic                      full;
   logic                      found;
   logic                      do_ins;
   logic                      do_del;

   // compare phase: every occupied cell against the incoming value
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cmp
      logic occ;
      assign occ      = CNT_W'(k) < count_ff;
      assign lt_in[k] = occ && (entries_ff[k] < req_value);
      assign eq_in[k] = occ && (entries_ff[k] == req_value);
   end

   assign full   = count_ff == CNT_W'(CAPACITY);
   // list is sorted, so any match means the first match sits right after the lt prefix
   assign found  = |eq_ff;
   assign do_ins = (op_ff == OP_INSERT) && !full;
   assign do_del = (op_ff == OP_DELETE) && found;

   // shift phase: cells below the lt prefix hold, the rest move one slot
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      always_comb begin
         entries_in[k] = entries_ff[k];
         if (!lt_ff[k]) begin
            if (do_ins) begin
               if (k == 0) begin
                  entries_in[k] = value_ff;
               end else if (lt_ff[(k > 0) ? k-1 : 0]) begin
                  entries_in[k] = value_ff;
               end else begin
                  entries_in[k] = entries_ff[(k > 0) ? k-1 : 0];
               end
            end else if (do_del && (k < CAPACITY - 1)) begin
               entries_in[k] = entries_ff[(k < CAPACITY - 1) ? k+1 : k];
            end
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = ST_DONE;
      unique case (op_ff)
         OP_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (found) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_opcode);
         value_ff <= req_value;
         lt_ff    <= lt_in;
         eq_ff    <= eq_in;
      end
      if (cmd.update) begin
         entries_ff <= entries_in;
         status_ff  <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.update) begin
         count_ff <= count_in;
      end
   end

   assign rsp_status      = STATUS_W'(status_ff);
   assign rsp_entry_count = ENTRY_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.update |=> $stable(count_ff))
      else $error("count changed outside an update");

   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      cmd.update && (op_ff == OP_INSERT) && full
      |=> $stable(count_ff) && (status_ff == ST_FULL))
      else $error("insert into full list not refused");

   a_lt_prefix: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> ((lt_ff & (lt_ff + CAPACITY'(1))) == '0))
      else $error("less-than flags not a prefix, list out of order");

endmodule : slid_datapath

`default_nettype wire

// ===== rtl/core/slid_ctrl.sv =====
// Controller: two-state sequencer for request acceptance, update and
// response handshake. Depends on slid_pkg; drives slid_datapath commands.
`default_nettype none

module slid_ctrl
   import slid_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      // response slot empties when taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            // only overwrite the response registers once the old one is gone
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.update   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> !(rsp_valid_ff && rsp_stall))
      else $error("pending response overwritten");

   a_capture_then_update: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == S_UPDATE))
      else $error("captured transaction not followed by update state");

   a_update_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_valid_ff)
      else $error("update did not raise response valid");

endmodule : slid_ctrl

`default_nettype wire

// ===== rtl/core/sorted_list_insert_delete.sv =====
// Sorted list insert/delete. The accept edge registers the compare of the value
// against all cells in parallel; the update edge that follows shifts the cells and
// loads the response. A new transaction is not taken until the previous one has
// been through its compare/shift sequence. A held response delays that update, so
// only one more transaction is taken while it waits.
// Synchronous reset empties the list and clears the handshake; cells keep data.
`default_nettype none

module sorted_list_insert_delete
   import slid_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_opcode,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [ENTRY_W-1:0]        rsp_entry_count
);

   cmd_type cmd;

   slid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   slid_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule : sorted_list_insert_delete

`default_nettype wire

// ===== tb/tb_sorted_list_insert_delete.sv =====
// Self-checking testbench for sorted_list_insert_delete: directed edge cases, full-store
// and random insert/delete traffic under random and long response back-pressure.
// Depends on slid_pkg and the sorted_list_insert_delete RTL.
`default_nettype none

module tb_sorted_list_insert_delete;
   import slid_pkg::*;

   localparam int LIST_DEPTH  = DEF_CAPACITY;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

   typedef struct {
      status_type           status;
      logic [ENTRY_W-1:0]   count;
   } list_result_type;

   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      req_valid       = 1'b0;
   logic                      req_stall;
   logic                      req_opcode      = 1'b0;
   logic signed [VALUE_W-1:0] req_value       = '0;
   logic                      rsp_valid;
   logic                      rsp_stall       = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic [ENTRY_W-1:0]        rsp_entry_count;

   // model of the held list, ascending
   logic signed [VALUE_W-1:0] held_values[$];
   list_result_type           pending_results[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left     = 0;
   int error_count   = 0;
   int cycle_count   = 0;

   sorted_list_insert_delete #(
      .CAPACITY(LIST_DEPTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: long hold-off when requested, random stalls otherwise
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic list_result_type apply_list_op(input op_type op,
                                                     input logic signed [VALUE_W-1:0] v);
      list_result_type res;
      int              pos;
      pos = 0;
      if (op == OP_INSERT) begin
         if (held_values.size() >= LIST_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            while (pos < held_values.size() && held_values[pos] < v) pos++;
            held_values.insert(pos, v);
            res.status = ST_DONE;
         end
      end else begin
         while (pos < held_values.size() && held_values[pos] != v) pos++;
         if (pos >= held_values.size()) begin
            res.status = ST_NOT_FOUND;
         end else begin
            held_values.delete(pos);
            res.status = ST_DONE;
         end
      end
      res.count = ENTRY_W'(held_values.size());
      return res;
   endfunction

   // mostly values that hit the list or collide, some extremes and full-range noise
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 35 && held_values.size() > 0)
         return held_values[$urandom_range(held_values.size() - 1)];
      if (sel < 65)
         return int'($urandom_range(16)) - 8;
      if (sel < 75) begin
         case ($urandom_range(3))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            default: return -1;
         endcase
      end
      return $urandom();
   endfunction

   task automatic send_op(input op_type op, input logic signed [VALUE_W-1:0] v);
      @(negedge clock);
      // sender idles cycle by cycle at the requested rate
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= v;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(apply_list_op(op, v));
   endtask

   task automatic test_directed_edges();
      send_op(OP_DELETE, 0);          // empty list
      send_op(OP_INSERT, VAL_MAX);
      send_op(OP_INSERT, VAL_MIN);
      send_op(OP_INSERT, 0);
      send_op(OP_INSERT, 0);          // duplicate
      send_op(OP_INSERT, -1);
      send_op(OP_DELETE, 0);          // only one of the duplicates goes
      send_op(OP_DELETE, 12345);      // absent value
      send_op(OP_DELETE, VAL_MIN);    // head removal
      send_op(OP_DELETE, VAL_MAX);    // tail removal
   endtask

   task automatic test_full_store();
      int k;
      for (k = 0; k < 14; k++) send_op(OP_INSERT, 100 - k * 7);
      send_op(OP_INSERT, VAL_MIN);    // store full, refused
   endtask

   task automatic test_random(input int items, input int snd_pct, input int rcv_pct);
      int done;
      int burst;
      int ins_pct;
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      done = 0;
      while (done < items) begin
         burst = $urandom_range(10, 40);
         // bias the insert rate per burst so the count wanders between empty and full
         case ($urandom_range(3))
            0: ins_pct = 25;
            1: ins_pct = 50;
            2: ins_pct = 75;
            default: ins_pct = 95;
         endcase
         repeat (burst) begin
            send_op(($urandom_range(99) < ins_pct) ? OP_INSERT : OP_DELETE, pick_value());
            done++;
         end
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left     = 300;
      repeat (40)
         send_op(($urandom_range(1) == 0) ? OP_INSERT : OP_DELETE, pick_value());
   endtask

   always @(posedge clock) begin : check_responses
      list_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transaction status=%0d count=%0d",
                     $time, rsp_status, rsp_entry_count);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_status !== exp_res.status) begin
               $display("%0t: status mismatch expected=%0d actual=%0d",
                        $time, exp_res.status, rsp_status);
               error_count++;
            end
            if (rsp_entry_count !== exp_res.count) begin
               $display("%0t: entry_count mismatch expected=%0d actual=%0d",
                        $time, exp_res.count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_full_store();
      test_random(450, 33, 59);
      test_backpressure();
      test_random(450, 59, 33);
      test_random(450, 0, 0);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
